// File: rtl/chm_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

  // Field and register widths.
  localparam int RAW_W     = 16;
  localparam int OFF_W     = 17;
  localparam int DECL_W    = 12;
  localparam int HEAD_W    = 15;
  localparam int CFG_IDX_W = 2;

  // Offset-corrected axis value: 2*raw - offset_sum, signed.
  localparam int CX_W      = OFF_W + 1;
  // Fraction bits added before the rotations.
  localparam int PRE_SHIFT = 8;
  // Vector datapath width, with headroom for the CORDIC gain and pre-rotation.
  localparam int XW        = 29;
  // Angle accumulator width, in 1/65536 degree.
  localparam int ZW        = 26;

  // Angle conversion from 1/65536 degree to 1/64 degree, rounding half up.
  localparam int ROUND_SHIFT = 10;
  localparam int ROUND_HALF  = 512;

  // Rotation count limits and default.
  localparam int ATAN_LEN          = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  // Angle constants.
  localparam int QUARTER_Z   = 5898240;
  localparam int FULL_CIRCLE = 23040;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECL  = 2'd2;

  // One vector in flight through the rotation chain.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 err;
  } chm_vec_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      0:       val = ZW'(2949120);
      1:       val = ZW'(1740967);
      2:       val = ZW'(919879);
      3:       val = ZW'(466945);
      4:       val = ZW'(234379);
      5:       val = ZW'(117304);
      6:       val = ZW'(58666);
      7:       val = ZW'(29335);
      8:       val = ZW'(14668);
      9:       val = ZW'(7334);
      10:      val = ZW'(3667);
      11:      val = ZW'(1833);
      12:      val = ZW'(917);
      13:      val = ZW'(458);
      14:      val = ZW'(229);
      15:      val = ZW'(115);
      16:      val = ZW'(57);
      17:      val = ZW'(29);
      18:      val = ZW'(14);
      19:      val = ZW'(7);
      20:      val = ZW'(4);
      21:      val = ZW'(2);
      22:      val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/compass_heading_from_mag_top.sv
// Registers in order: chm_prep, the CORDIC_STAGES rotation cells, chm_post.
// Throughput: one beat per cycle while m_axis_tready is high; every stage is
// a register with its own valid bit, so bubbles close up and a held result
// stalls only what is behind. Reset clears all valid bits, sets both offset
// sums to 65536 and declination to 0. Payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_from_mag_top #(
  parameter int CORDIC_STAGES = chm_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Slave side: tdata = raw_x [15:0], raw_y [31:16].
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,
  // Master side: tdata = heading [14:0], zero fill [15].
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [15:0]                        m_axis_tdata,
  // Master side: tuser = zero_axis_error [0].
  output logic                               m_axis_tuser,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [chm_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [chm_pkg::OFF_W-1:0]     cfg_wdata_i
);
  import chm_pkg::*;

  logic [OFF_W-1:0]         off_x_q;
  logic [OFF_W-1:0]         off_y_q;
  logic signed [DECL_W-1:0] decl_q;

  chm_vec_t vec   [0:CORDIC_STAGES];
  logic     vld   [0:CORDIC_STAGES];
  logic     rdy   [0:CORDIC_STAGES];

  logic [HEAD_W-1:0] heading;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= OFF_W'(65536);
      off_y_q <= OFF_W'(65536);
      decl_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_OFF_X: off_x_q <= cfg_wdata_i;
        CFG_OFF_Y: off_y_q <= cfg_wdata_i;
        CFG_DECL:  decl_q  <= cfg_wdata_i[DECL_W-1:0];
        default:   ;
      endcase
    end
  end

  // Offset removal and pre-rotation.
  chm_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .raw_x_i     (s_axis_tdata[RAW_W-1:0]),
    .raw_y_i     (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .off_x_i     (off_x_q),
    .off_y_i     (off_y_q),
    .out_valid_o (vld[0]),
    .out_ready_i (rdy[0]),
    .out_vec_o   (vec[0])
  );

  // Chain of rotation cells.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    chm_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .in_vec_i    (vec[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .out_vec_o   (vec[g+1])
    );
  end

  // Rounding, declination and wrap; holds the result beat.
  chm_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[CORDIC_STAGES]),
    .in_ready_o  (rdy[CORDIC_STAGES]),
    .in_vec_i    (vec[CORDIC_STAGES]),
    .decl_i      (decl_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .heading_o   (heading),
    .err_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, heading};

endmodule

`default_nettype wire

// File: rtl/chm_prep.sv
// Input stage: offset removal, scaling and quadrant pre-rotation.
`timescale 1ns / 1ps
`default_nettype none

module chm_prep (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [chm_pkg::RAW_W-1:0]   raw_x_i,
  input  wire logic [chm_pkg::RAW_W-1:0]   raw_y_i,
  input  wire logic [chm_pkg::OFF_W-1:0]   off_x_i,
  input  wire logic [chm_pkg::OFF_W-1:0]   off_y_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output chm_pkg::chm_vec_t                out_vec_o
);
  import chm_pkg::*;

  logic signed [CX_W-1:0] cx;
  logic signed [CX_W-1:0] cy;
  logic signed [XW-1:0]   xs;
  logic signed [XW-1:0]   ys;
  chm_vec_t               vec_d;
  chm_vec_t               vec_q;
  logic                   valid_q;

  // Offset-corrected axes, exact in CX_W bits.
  assign cx = $signed({1'b0, raw_x_i, 1'b0}) - $signed({1'b0, off_x_i});
  assign cy = $signed({1'b0, raw_y_i, 1'b0}) - $signed({1'b0, off_y_i});

  // Sign-extend and add fraction bits.
  assign xs = {{(XW-CX_W-PRE_SHIFT){cx[CX_W-1]}}, cx, {PRE_SHIFT{1'b0}}};
  assign ys = {{(XW-CX_W-PRE_SHIFT){cy[CX_W-1]}}, cy, {PRE_SHIFT{1'b0}}};

  // Flag a zero axis and bring left-half vectors into the right half plane.
  always_comb begin
    vec_d.err = (cx == '0) || (cy == '0);
    if (xs < 0) begin
      if (ys > 0) begin
        vec_d.x = ys;
        vec_d.y = -xs;
        vec_d.z = ZW'(QUARTER_Z);
      end else begin
        vec_d.x = -ys;
        vec_d.y = xs;
        vec_d.z = -ZW'(QUARTER_Z);
      end
    end else begin
      vec_d.x = xs;
      vec_d.y = ys;
      vec_d.z = '0;
    end
  end

  // The stage takes a beat when it is empty or its content moves on.
  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;

endmodule

`default_nettype wire

// File: rtl/chm_cordic_cell.sv
// One CORDIC vectoring rotation with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module chm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire chm_pkg::chm_vec_t in_vec_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output chm_pkg::chm_vec_t      out_vec_o
);
  import chm_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  chm_vec_t             vec_d;
  chm_vec_t             vec_q;
  logic                 valid_q;

  // Arithmetic shifts round toward minus infinity.
  assign dx = in_vec_i.y >>> STAGE;
  assign dy = in_vec_i.x >>> STAGE;

  // Rotate toward the x axis and accumulate the angle.
  always_comb begin
    vec_d.err = in_vec_i.err;
    if (in_vec_i.y > 0) begin
      vec_d.x = in_vec_i.x + dx;
      vec_d.y = in_vec_i.y - dy;
      vec_d.z = in_vec_i.z + atan_q16(STAGE);
    end else begin
      vec_d.x = in_vec_i.x - dx;
      vec_d.y = in_vec_i.y + dy;
      vec_d.z = in_vec_i.z - atan_q16(STAGE);
    end
  end

  // Local handshake: take a beat when empty or when the content moves on.
  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;

endmodule

`default_nettype wire

// File: rtl/chm_post.sv
// Output stage: angle rounding, declination, wrap to [0, 360) degrees.
`timescale 1ns / 1ps
`default_nettype none

module chm_post (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire chm_pkg::chm_vec_t                in_vec_i,
  input  wire logic signed [chm_pkg::DECL_W-1:0] decl_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [chm_pkg::HEAD_W-1:0]            heading_o,
  output logic                                  err_o
);
  import chm_pkg::*;

  localparam int HW = ZW - ROUND_SHIFT + 1;
  localparam logic signed [HW-1:0] FULL_H = HW'(FULL_CIRCLE);

  logic signed [ZW-1:0]                zr;
  logic signed [ZW-ROUND_SHIFT-1:0]    hr;
  logic signed [HW-1:0]                hd;
  logic signed [HW-1:0]                hw;
  logic signed [HW-1:0]                hf;
  logic [HEAD_W-1:0]                   heading_d;
  logic [HEAD_W-1:0]                   heading_q;
  logic                                err_q;
  logic                                valid_q;

  // Round to 1/64 degree, half up.
  assign zr = in_vec_i.z + ZW'(ROUND_HALF);
  assign hr = zr[ZW-1:ROUND_SHIFT];

  // Add declination and wrap into one turn; a zero-axis flag forces heading 0.
  always_comb begin
    hd = {hr[ZW-ROUND_SHIFT-1], hr} + {{(HW-DECL_W){decl_i[DECL_W-1]}}, decl_i};
    hw = (hd < 0) ? hd + FULL_H : hd;
    if (hw < 0) begin
      hw = '0;
    end
    hf = (hw >= FULL_H) ? hw - FULL_H : hw;
    heading_d = in_vec_i.err ? '0 : hf[HEAD_W-1:0];
  end

  // This register is the output register of the block.
  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      heading_q <= heading_d;
      err_q     <= in_vec_i.err;
    end
  end

  assign out_valid_o = valid_q;
  assign heading_o   = heading_q;
  assign err_o       = err_q;

endmodule

`default_nettype wire
